// ----- hw/rtl/fcpu_pkg.sv -----
// Shared types, constants and arithmetic helpers for the fly camera pose update core.
// Depends on nothing; imported by fly_camera_pose_update_core and the bench in dv/tb.sv.
`default_nettype none

package fcpu_pkg;

    // Angle constants in Q9.16 degrees
    localparam int DEG180    = 11796480;
    localparam int DEG90     = 5898240;
    localparam int PITCH_MAX = 5242880;

    // CORDIC start value (gain compensated), Q2.30, and the clamp limit
    localparam int CORDIC_GAIN = 652032874;
    localparam int ONE_Q30     = 1073741824;
    localparam int UNIT_Q14    = 16384;
    localparam int ATAN_LEN    = 24;

    // Arctangent of 2^-i in Q16 degrees
    localparam logic signed [22:0] ATAN_TBL [0:ATAN_LEN-1] = '{
        23'sd2949120, 23'sd1740967, 23'sd919879, 23'sd466945,
        23'sd234379,  23'sd117305,  23'sd58666,  23'sd29335,
        23'sd14668,   23'sd7334,    23'sd3667,   23'sd1833,
        23'sd917,     23'sd458,     23'sd229,    23'sd115,
        23'sd57,      23'sd29,      23'sd14,     23'sd7,
        23'sd4,       23'sd2,       23'sd1,      23'sd0
    };

    // Event kinds
    localparam logic CMD_MOVE = 1'b0;
    localparam logic CMD_LOOK = 1'b1;

    // Move directions
    localparam logic [2:0] DIR_FWD   = 3'd0;
    localparam logic [2:0] DIR_BACK  = 3'd1;
    localparam logic [2:0] DIR_LEFT  = 3'd2;
    localparam logic [2:0] DIR_RIGHT = 3'd3;
    localparam logic [2:0] DIR_UP    = 3'd4;
    localparam logic [2:0] DIR_DOWN  = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] REG_UP_X        = 3'd0;
    localparam logic [2:0] REG_UP_Y        = 3'd1;
    localparam logic [2:0] REG_UP_Z        = 3'd2;
    localparam logic [2:0] REG_START_X     = 3'd3;
    localparam logic [2:0] REG_START_Y     = 3'd4;
    localparam logic [2:0] REG_START_Z     = 3'd5;
    localparam logic [2:0] REG_START_YAW   = 3'd6;
    localparam logic [2:0] REG_START_PITCH = 3'd7;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LK0,
        S_LK1,
        S_LK2,
        S_WRAP,
        S_CINIT,
        S_CITER,
        S_CEND,
        S_FM0,
        S_FM1,
        S_FM2,
        S_BR,
        S_CROSS,
        S_SQ,
        S_SQRT,
        S_NCHK,
        S_DINIT,
        S_DIV,
        S_DEND,
        S_PM0,
        S_PM1,
        S_PM2,
        S_PM3,
        S_DONE
    } fcpu_state_t;

    // Shift right by s with rounding to nearest, ties away from zero
    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v, input int s);
        logic [63:0] mag;
        logic [63:0] r;
        mag = v[63] ? 64'(-v) : 64'(v);
        r   = (mag + (64'd1 << (s - 1))) >> s;
        return v[63] ? -$signed(r) : $signed(r);
    endfunction

    // Clamp to a Q1.14 unit component
    function automatic logic signed [15:0] sat_unit(input logic signed [63:0] v);
        if (v > 64'(UNIT_Q14))
            return 16'(UNIT_Q14);
        else if (v < 64'(-UNIT_Q14))
            return 16'(-UNIT_Q14);
        else
            return v[15:0];
    endfunction

    // Add a rounded velocity step to a coordinate and saturate to 32 bits
    function automatic logic signed [31:0] pos_step(input logic signed [31:0] p,
                                                    input logic signed [63:0] prod,
                                                    input logic neg);
        logic signed [63:0] d;
        logic signed [33:0] s;
        d = rnd_shr(prod, 14);
        s = 34'(p) + (neg ? -d[33:0] : d[33:0]);
        if (s > 34'sd2147483647)
            return 32'sh7fffffff;
        else if (s < -34'sd2147483648)
            return 32'sh80000000;
        else
            return s[31:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/fly_camera_pose_update_core.sv -----
// Fly camera pose update core: sequencer around one shared multiplier, a CORDIC
// datapath, a square-root loop and a restoring divider. Uses fcpu_pkg.
// A look event scales the offsets, wraps yaw, then runs the yaw and pitch CORDIC
// rotations and forms the front vector; a move runs the rotations and front vector,
// then steps the position along forward/back or up/down; an unknown direction
// leaves the position. Left/right adds the cross product, its sum of squares, the
// 64-bit square-root loop and three bit-serial divides to normalise it.
// One event at a time; the next beat can be taken in the cycle after the result is
// loaded, while that result waits in the output register.
// Reset loads up (0,1,0), position 0, yaw -90 and pitch 0 degrees.
`default_nettype none

module fly_camera_pose_update_core
    import fcpu_pkg::*;
#(
    parameter int SENSITIVITY_Q16 = 6554,
    parameter int CORDIC_STEPS    = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // direction[2:0], delta_time[18:3], x_offset[34:19], y_offset[50:35], zero fill
    input  wire logic [55:0]  s_axis_tdata,
    // cmd[0]
    input  wire logic [0:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], front_x[111:96], front_y[127:112],
    // front_z[143:128], yaw_out[168:144], pitch_out[192:169], zero fill
    output logic [199:0]      m_axis_tdata,
    // degenerate[0]
    output logic [0:0]        m_axis_tuser,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    localparam logic signed [31:0] SENS32   = 32'(SENSITIVITY_Q16);
    localparam logic [5:0]         CLAST    = 6'(CORDIC_STEPS - 1);

    // Control and architectural state
    fcpu_state_t        state_reg, state_next;
    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next, pos_z_reg, pos_z_next;
    logic signed [29:0] yaw_reg, yaw_next;
    logic signed [23:0] pitch_reg, pitch_next;
    logic signed [15:0] up_x_reg, up_x_next, up_y_reg, up_y_next, up_z_reg, up_z_next;

    // Working registers
    logic [5:0]         cnt_reg, cnt_next;
    logic               phase_reg, phase_next;
    logic               cneg_reg, cneg_next;
    logic signed [33:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [25:0] cz_reg, cz_next;
    logic signed [31:0] cos_y_reg, cos_y_next, sin_y_reg, sin_y_next;
    logic signed [31:0] cos_p_reg, cos_p_next, sin_p_reg, sin_p_next;
    logic signed [15:0] f0_reg, f0_next, f1_reg, f1_next, f2_reg, f2_next;
    logic               cmd_reg, cmd_next;
    logic [2:0]         dir_reg, dir_next;
    logic [18:0]        vel_reg, vel_next;
    logic signed [15:0] xo_reg, xo_next, yo_reg, yo_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [31:0] c0_reg, c0_next, c1_reg, c1_next, c2_reg, c2_next;
    logic [63:0]        sq_reg, sq_next, sr_reg, sr_next, sbit_reg, sbit_next;
    logic [31:0]        n_reg, n_next;
    logic [46:0]        dvd_reg, dvd_next, dsr_reg, dsr_next;
    logic [14:0]        q_reg, q_next;
    logic [1:0]         j_reg, j_next;
    logic signed [15:0] vx_reg, vx_next, vy_reg, vy_next, vz_reg, vz_next;
    logic               neg_reg, neg_next;
    logic               degen_reg, degen_next;
    logic [199:0]       out_data_reg, out_data_next;
    logic               out_degen_reg, out_degen_next;

    // Shared multiplier operands
    logic signed [31:0] mul_a, mul_b;

    // Combinational temporaries
    logic signed [63:0] rt;
    logic signed [29:0] wide;
    logic signed [25:0] ang;
    logic signed [33:0] xs, ys, clx, cly, resx, resy;
    logic signed [25:0] at;
    logic [4:0]         sh;
    logic [63:0]        rb;
    logic signed [31:0] cj;
    logic [31:0]        mag;
    logic signed [15:0] qs;
    logic               accept;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_degen_reg;

    // Registered product of the shared multiplier
    assign prod_next = mul_a * mul_b;

    // Next state, datapath and multiplier operand selection
    always_comb
    begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        pos_z_next     = pos_z_reg;
        yaw_next       = yaw_reg;
        pitch_next     = pitch_reg;
        up_x_next      = up_x_reg;
        up_y_next      = up_y_reg;
        up_z_next      = up_z_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        cneg_next      = cneg_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        cos_y_next     = cos_y_reg;
        sin_y_next     = sin_y_reg;
        cos_p_next     = cos_p_reg;
        sin_p_next     = sin_p_reg;
        f0_next        = f0_reg;
        f1_next        = f1_reg;
        f2_next        = f2_reg;
        cmd_next       = cmd_reg;
        dir_next       = dir_reg;
        vel_next       = vel_reg;
        xo_next        = xo_reg;
        yo_next        = yo_reg;
        c0_next        = c0_reg;
        c1_next        = c1_reg;
        c2_next        = c2_reg;
        sq_next        = sq_reg;
        sr_next        = sr_reg;
        sbit_next      = sbit_reg;
        n_next         = n_reg;
        dvd_next       = dvd_reg;
        dsr_next       = dsr_reg;
        q_next         = q_reg;
        j_next         = j_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        vz_next        = vz_reg;
        neg_next       = neg_reg;
        degen_next     = degen_reg;
        out_data_next  = out_data_reg;
        out_degen_next = out_degen_reg;
        mul_a          = '0;
        mul_b          = '0;
        rt             = '0;
        wide           = '0;
        ang            = '0;
        xs             = '0;
        ys             = '0;
        clx            = '0;
        cly            = '0;
        resx           = '0;
        resy           = '0;
        at             = '0;
        sh             = cnt_reg[4:0];
        rb             = '0;
        cj             = '0;
        mag            = '0;
        qs             = '0;

        case (state_reg)
            S_IDLE:
            begin
                // Configuration writes land only while idle
                if (cfg_we)
                begin
                    case (cfg_index)
                        REG_UP_X:        up_x_next  = cfg_data[15:0];
                        REG_UP_Y:        up_y_next  = cfg_data[15:0];
                        REG_UP_Z:        up_z_next  = cfg_data[15:0];
                        REG_START_X:     pos_x_next = cfg_data;
                        REG_START_Y:     pos_y_next = cfg_data;
                        REG_START_Z:     pos_z_next = cfg_data;
                        REG_START_YAW:
                        begin
                            wide = 30'($signed(cfg_data[24:0]));
                            if (wide >= 30'(DEG180))
                                wide = wide - 30'(2 * DEG180);
                            else if (wide < 30'(-DEG180))
                                wide = wide + 30'(2 * DEG180);
                            yaw_next = wide;
                        end
                        REG_START_PITCH:
                        begin
                            wide = 30'($signed(cfg_data[23:0]));
                            if (wide > 30'(PITCH_MAX))
                                wide = 30'(PITCH_MAX);
                            else if (wide < 30'(-PITCH_MAX))
                                wide = 30'(-PITCH_MAX);
                            pitch_next = wide[23:0];
                        end
                        default: ;
                    endcase
                end
                // Take the event beat
                if (accept)
                begin
                    cmd_next   = s_axis_tuser[0];
                    dir_next   = s_axis_tdata[2:0];
                    vel_next   = {s_axis_tdata[18:3], 2'b00} + 19'(s_axis_tdata[18:3]);
                    xo_next    = s_axis_tdata[34:19];
                    yo_next    = s_axis_tdata[50:35];
                    degen_next = 1'b0;
                    phase_next = 1'b0;
                    state_next = (s_axis_tuser[0] == CMD_LOOK) ? S_LK0 : S_CINIT;
                end
            end

            S_LK0:
            begin
                mul_a      = 32'(xo_reg);
                mul_b      = SENS32;
                state_next = S_LK1;
            end

            S_LK1:
            begin
                rt         = rnd_shr(prod_reg, 4);
                yaw_next   = yaw_reg + rt[29:0];
                mul_a      = 32'(yo_reg);
                mul_b      = SENS32;
                state_next = S_LK2;
            end

            S_LK2:
            begin
                rt   = rnd_shr(prod_reg, 4);
                wide = 30'(pitch_reg) + rt[29:0];
                if (wide > 30'(PITCH_MAX))
                    wide = 30'(PITCH_MAX);
                else if (wide < 30'(-PITCH_MAX))
                    wide = 30'(-PITCH_MAX);
                pitch_next = wide[23:0];
                state_next = S_WRAP;
            end

            // Bring yaw back into [-180,180) one turn per cycle
            S_WRAP:
            begin
                if (yaw_reg >= 30'(DEG180))
                    yaw_next = yaw_reg - 30'(2 * DEG180);
                else if (yaw_reg < 30'(-DEG180))
                    yaw_next = yaw_reg + 30'(2 * DEG180);
                else
                    state_next = S_CINIT;
            end

            // Fold the angle into [-90,90] and seed the rotation
            S_CINIT:
            begin
                ang       = phase_reg ? 26'(pitch_reg) : yaw_reg[25:0];
                cneg_next = 1'b0;
                if (ang > 26'(DEG90))
                begin
                    ang       = ang - 26'(2 * DEG90);
                    cneg_next = 1'b1;
                end
                else if (ang < 26'(-DEG90))
                begin
                    ang       = ang + 26'(2 * DEG90);
                    cneg_next = 1'b1;
                end
                cz_next    = ang;
                cx_next    = 34'(CORDIC_GAIN);
                cy_next    = '0;
                cnt_next   = '0;
                state_next = S_CITER;
            end

            // One CORDIC micro-rotation per cycle
            S_CITER:
            begin
                xs = cx_reg >>> sh;
                ys = cy_reg >>> sh;
                at = 26'(ATAN_TBL[sh]);
                if (!cz_reg[25])
                begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    cz_next = cz_reg - at;
                end
                else
                begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    cz_next = cz_reg + at;
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == CLAST)
                    state_next = S_CEND;
            end

            // Clamp, undo the fold and store cosine and sine
            S_CEND:
            begin
                clx = cx_reg;
                cly = cy_reg;
                if (clx > 34'(ONE_Q30))
                    clx = 34'(ONE_Q30);
                else if (clx < 34'(-ONE_Q30))
                    clx = 34'(-ONE_Q30);
                if (cly > 34'(ONE_Q30))
                    cly = 34'(ONE_Q30);
                else if (cly < 34'(-ONE_Q30))
                    cly = 34'(-ONE_Q30);
                resx = cneg_reg ? -clx : clx;
                resy = cneg_reg ? -cly : cly;
                if (!phase_reg)
                begin
                    cos_y_next = resx[31:0];
                    sin_y_next = resy[31:0];
                    phase_next = 1'b1;
                    state_next = S_CINIT;
                end
                else
                begin
                    cos_p_next = resx[31:0];
                    sin_p_next = resy[31:0];
                    state_next = S_FM0;
                end
            end

            S_FM0:
            begin
                mul_a      = cos_y_reg;
                mul_b      = cos_p_reg;
                state_next = S_FM1;
            end

            S_FM1:
            begin
                f0_next    = sat_unit(rnd_shr(prod_reg, 46));
                mul_a      = sin_y_reg;
                mul_b      = cos_p_reg;
                state_next = S_FM2;
            end

            S_FM2:
            begin
                f2_next    = sat_unit(rnd_shr(prod_reg, 46));
                f1_next    = sat_unit(rnd_shr(64'(sin_p_reg), 16));
                state_next = (cmd_reg == CMD_LOOK) ? S_DONE : S_BR;
            end

            // Pick the step vector for a move
            S_BR:
            begin
                case (dir_reg)
                    DIR_FWD, DIR_BACK:
                    begin
                        vx_next    = f0_reg;
                        vy_next    = f1_reg;
                        vz_next    = f2_reg;
                        neg_next   = (dir_reg == DIR_BACK);
                        state_next = S_PM0;
                    end
                    DIR_UP, DIR_DOWN:
                    begin
                        vx_next    = up_x_reg;
                        vy_next    = up_y_reg;
                        vz_next    = up_z_reg;
                        neg_next   = (dir_reg == DIR_DOWN);
                        state_next = S_PM0;
                    end
                    DIR_LEFT, DIR_RIGHT:
                    begin
                        c0_next    = '0;
                        c1_next    = '0;
                        c2_next    = '0;
                        cnt_next   = '0;
                        state_next = S_CROSS;
                    end
                    default:
                        state_next = S_DONE;
                endcase
            end

            // Cross product front x up: issue one term, accumulate the previous
            S_CROSS:
            begin
                case (cnt_reg)
                    6'd0:
                    begin
                        mul_a = 32'(f1_reg);
                        mul_b = 32'(up_z_reg);
                    end
                    6'd1:
                    begin
                        mul_a = 32'(f2_reg);
                        mul_b = 32'(up_y_reg);
                    end
                    6'd2:
                    begin
                        mul_a = 32'(f2_reg);
                        mul_b = 32'(up_x_reg);
                    end
                    6'd3:
                    begin
                        mul_a = 32'(f0_reg);
                        mul_b = 32'(up_z_reg);
                    end
                    6'd4:
                    begin
                        mul_a = 32'(f0_reg);
                        mul_b = 32'(up_y_reg);
                    end
                    6'd5:
                    begin
                        mul_a = 32'(f1_reg);
                        mul_b = 32'(up_x_reg);
                    end
                    default: ;
                endcase
                case (cnt_reg)
                    6'd1:    c0_next = c0_reg + prod_reg[31:0];
                    6'd2:    c0_next = c0_reg - prod_reg[31:0];
                    6'd3:    c1_next = c1_reg + prod_reg[31:0];
                    6'd4:    c1_next = c1_reg - prod_reg[31:0];
                    6'd5:    c2_next = c2_reg + prod_reg[31:0];
                    6'd6:    c2_next = c2_reg - prod_reg[31:0];
                    default: ;
                endcase
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd6)
                begin
                    cnt_next   = '0;
                    sq_next    = '0;
                    state_next = S_SQ;
                end
            end

            // Sum of squares of the cross product
            S_SQ:
            begin
                case (cnt_reg)
                    6'd0:
                    begin
                        mul_a = c0_reg;
                        mul_b = c0_reg;
                    end
                    6'd1:
                    begin
                        mul_a = c1_reg;
                        mul_b = c1_reg;
                    end
                    6'd2:
                    begin
                        mul_a = c2_reg;
                        mul_b = c2_reg;
                    end
                    default: ;
                endcase
                if (cnt_reg != 6'd0)
                    sq_next = sq_reg + 64'(prod_reg);
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd3)
                begin
                    sr_next    = '0;
                    sbit_next  = 64'd1 << 62;
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
            end

            // Integer square root, two radicand bits per cycle
            S_SQRT:
            begin
                rb = sr_reg + sbit_reg;
                if (sq_reg >= rb)
                begin
                    sq_next = sq_reg - rb;
                    sr_next = (sr_reg >> 1) + sbit_reg;
                end
                else
                    sr_next = sr_reg >> 1;
                sbit_next = sbit_reg >> 2;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                    state_next = S_NCHK;
            end

            // Zero norm: no motion, flag it
            S_NCHK:
            begin
                if (sr_reg == 64'd0)
                begin
                    degen_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    n_next     = sr_reg[31:0];
                    j_next     = '0;
                    state_next = S_DINIT;
                end
            end

            // Set up |c| * 2^14 + n/2 over n
            S_DINIT:
            begin
                case (j_reg)
                    2'd0:    cj = c0_reg;
                    2'd1:    cj = c1_reg;
                    default: cj = c2_reg;
                endcase
                mag        = cj[31] ? 32'(-cj) : 32'(cj);
                dvd_next   = {1'b0, mag, 14'd0} + 47'(n_reg >> 1);
                dsr_next   = {1'b0, n_reg, 14'd0};
                q_next     = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end

            // Restoring division, one quotient bit per cycle
            S_DIV:
            begin
                if (dvd_reg >= dsr_reg)
                begin
                    dvd_next = dvd_reg - dsr_reg;
                    q_next   = {q_reg[13:0], 1'b1};
                end
                else
                    q_next = {q_reg[13:0], 1'b0};
                dsr_next = dsr_reg >> 1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd14)
                    state_next = S_DEND;
            end

            // Store the signed unit component
            S_DEND:
            begin
                case (j_reg)
                    2'd0:    cj = c0_reg;
                    2'd1:    cj = c1_reg;
                    default: cj = c2_reg;
                endcase
                qs = cj[31] ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
                case (j_reg)
                    2'd0:    vx_next = qs;
                    2'd1:    vy_next = qs;
                    default: vz_next = qs;
                endcase
                j_next = j_reg + 2'd1;
                if (j_reg == 2'd2)
                begin
                    neg_next   = (dir_reg == DIR_LEFT);
                    state_next = S_PM0;
                end
                else
                    state_next = S_DINIT;
            end

            // Step the position by velocity times the chosen vector
            S_PM0:
            begin
                mul_a      = 32'({1'b0, vel_reg});
                mul_b      = 32'(vx_reg);
                state_next = S_PM1;
            end

            S_PM1:
            begin
                pos_x_next = pos_step(pos_x_reg, prod_reg, neg_reg);
                mul_a      = 32'({1'b0, vel_reg});
                mul_b      = 32'(vy_reg);
                state_next = S_PM2;
            end

            S_PM2:
            begin
                pos_y_next = pos_step(pos_y_reg, prod_reg, neg_reg);
                mul_a      = 32'({1'b0, vel_reg});
                mul_b      = 32'(vz_reg);
                state_next = S_PM3;
            end

            S_PM3:
            begin
                pos_z_next = pos_step(pos_z_reg, prod_reg, neg_reg);
                state_next = S_DONE;
            end

            // Hand the result to the output register once it is free
            S_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_data_next  = {7'd0, pitch_reg, yaw_reg[24:0], f2_reg, f1_reg, f0_reg,
                                      pos_z_reg, pos_y_reg, pos_x_reg};
                    out_degen_next = degen_reg;
                    m_valid_next   = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // Control and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            pos_z_reg   <= '0;
            yaw_reg     <= 30'(-DEG90);
            pitch_reg   <= '0;
            up_x_reg    <= '0;
            up_y_reg    <= 16'(UNIT_Q14);
            up_z_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            pos_z_reg   <= pos_z_next;
            yaw_reg     <= yaw_next;
            pitch_reg   <= pitch_next;
            up_x_reg    <= up_x_next;
            up_y_reg    <= up_y_next;
            up_z_reg    <= up_z_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        phase_reg     <= phase_next;
        cneg_reg      <= cneg_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        cz_reg        <= cz_next;
        cos_y_reg     <= cos_y_next;
        sin_y_reg     <= sin_y_next;
        cos_p_reg     <= cos_p_next;
        sin_p_reg     <= sin_p_next;
        f0_reg        <= f0_next;
        f1_reg        <= f1_next;
        f2_reg        <= f2_next;
        cmd_reg       <= cmd_next;
        dir_reg       <= dir_next;
        vel_reg       <= vel_next;
        xo_reg        <= xo_next;
        yo_reg        <= yo_next;
        prod_reg      <= prod_next;
        c0_reg        <= c0_next;
        c1_reg        <= c1_next;
        c2_reg        <= c2_next;
        sq_reg        <= sq_next;
        sr_reg        <= sr_next;
        sbit_reg      <= sbit_next;
        n_reg         <= n_next;
        dvd_reg       <= dvd_next;
        dsr_reg       <= dsr_next;
        q_reg         <= q_next;
        j_reg         <= j_next;
        vx_reg        <= vx_next;
        vy_reg        <= vy_next;
        vz_reg        <= vz_next;
        neg_reg       <= neg_next;
        degen_reg     <= degen_next;
        out_data_reg  <= out_data_next;
        out_degen_reg <= out_degen_next;
    end

    // Accepted beat always starts work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("beat accepted but sequencer stayed idle");

    // A pending result is never overwritten
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && m_valid_reg && !m_axis_tready) |=> state_reg == S_DONE)
        else $error("result register overwritten while full");

    // Pitch stays clamped between events
    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> (pitch_reg <= 24'(PITCH_MAX) && pitch_reg >= 24'(-PITCH_MAX)))
        else $error("pitch out of range");

    // Yaw stays wrapped between events
    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> (yaw_reg < 30'(DEG180) && yaw_reg >= 30'(-DEG180)))
        else $error("yaw out of range");

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking bench for fly_camera_pose_update_core: a stream driver, a result monitor
// and a fixed-point pose predictor built on fcpu_pkg constants. Needs only the RTL.
`default_nettype none

module tb;
    import fcpu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  TURN_STEPS = 16;
    localparam int  SENS       = 6554;
    localparam int  SETTLE     = 200;
    localparam int  MAX_GAP    = 18;

    typedef enum logic [1:0] {OP_EVENT, OP_CFG, OP_DRAIN} op_kind_t;

    typedef struct {
        op_kind_t    kind;
        logic        cmd;
        logic [2:0]  dir;
        logic [15:0] dt;
        logic [15:0] xo;
        logic [15:0] yo;
        logic [2:0]  idx;
        logic [31:0] val;
        bit          nogap;
    } op_t;

    typedef struct {
        logic [31:0] px, py, pz;
        logic [15:0] fx, fy, fz;
        logic [24:0] yaw;
        logic [23:0] pitch;
        logic        degen;
    } pose_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic [55:0]  s_data = '0;
    logic [0:0]   s_user = '0;
    logic         m_ready = 1'b0;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;
    wire          s_ready;
    wire          m_valid;
    wire [199:0]  m_data;
    wire [0:0]    m_user;

    op_t    pending[$];
    pose_t  pose_due[$];
    op_t    cur_op;
    int     gap_left = 0;
    int     settle_cnt = 0;
    int     stall_left = 0;
    int     n_fail = 0;
    int     n_results = 0;
    int     n_events = 0;
    int     n_cfg = 0;
    int     n_degen = 0;

    // predictor state
    longint up_v[3];
    longint pos_v[3];
    longint yaw_q, pitch_q;

    fly_camera_pose_update_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
        .s_axis_tdata(s_data), .s_axis_tuser(s_user),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
        .m_axis_tdata(m_data), .m_axis_tuser(m_user),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint sx(longint v, int w);
        longint m;
        m = (longint'(1) << w) - 1;
        v = v & m;
        if (v[w-1])
            v = v - (longint'(1) << w);
        return v;
    endfunction

    function automatic longint round_shr(longint v, int s);
        longint h;
        h = longint'(1) << (s - 1);
        if (v >= 0)
            return (v + h) >>> s;
        return -((-v + h) >>> s);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint wrap_deg(longint a);
        longint p, r;
        p = 2 * longint'(DEG180);
        r = (a + DEG180) % p;
        if (r < 0)
            r += p;
        return r - DEG180;
    endfunction

    // CORDIC rotation in degrees, half-turn folded into [-90,90]
    function automatic void rotate_deg(input longint a, output longint c, output longint s);
        bit     neg;
        longint x, y, z, nx;
        neg = 0;
        x = CORDIC_GAIN;
        y = 0;
        if (a > DEG90)
        begin
            a -= 2 * longint'(DEG90);
            neg = 1;
        end
        else if (a < -DEG90)
        begin
            a += 2 * longint'(DEG90);
            neg = 1;
        end
        z = a;
        for (int i = 0; i < TURN_STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= ATAN_TBL[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += ATAN_TBL[i];
            end
            x = nx;
        end
        x = clip(x, -ONE_Q30, ONE_Q30);
        y = clip(y, -ONE_Q30, ONE_Q30);
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unit_part(longint c, longint unsigned n);
        longint unsigned a;
        longint q;
        a = longint'(c < 0 ? -c : c) << 14;
        q = longint'((a + n / 2) / n);
        return c < 0 ? -q : q;
    endfunction

    task automatic apply_cfg(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            REG_UP_X:        up_v[0] = sx(val, 16);
            REG_UP_Y:        up_v[1] = sx(val, 16);
            REG_UP_Z:        up_v[2] = sx(val, 16);
            REG_START_X:     pos_v[0] = sx(val, 32);
            REG_START_Y:     pos_v[1] = sx(val, 32);
            REG_START_Z:     pos_v[2] = sx(val, 32);
            REG_START_YAW:   yaw_q = wrap_deg(sx(val, 25));
            REG_START_PITCH: pitch_q = clip(sx(val, 24), -PITCH_MAX, PITCH_MAX);
            default: ;
        endcase
    endtask

    // Advance the pose by one event and return the result it produces
    function automatic pose_t next_pose(op_t op);
        pose_t  r;
        longint cy, sy, cp, sp, vel, sgn;
        longint f[3], v[3], c[3];
        longint unsigned n;
        bit     moved, degen;
        moved = 0;
        degen = 0;
        sgn = 1;
        v = '{0, 0, 0};
        if (op.cmd == CMD_LOOK)
        begin
            yaw_q = wrap_deg(yaw_q + round_shr(sx(op.xo, 16) * SENS, 4));
            pitch_q = clip(pitch_q + round_shr(sx(op.yo, 16) * SENS, 4),
                           -PITCH_MAX, PITCH_MAX);
        end
        rotate_deg(yaw_q, cy, sy);
        rotate_deg(pitch_q, cp, sp);
        f[0] = clip(round_shr(cy * cp, 46), -UNIT_Q14, UNIT_Q14);
        f[1] = clip(round_shr(sp, 16), -UNIT_Q14, UNIT_Q14);
        f[2] = clip(round_shr(sy * cp, 46), -UNIT_Q14, UNIT_Q14);
        if (op.cmd == CMD_MOVE)
        begin
            vel = 5 * longint'(op.dt);
            case (op.dir)
                DIR_FWD, DIR_BACK:
                begin
                    v = f;
                    sgn = (op.dir == DIR_FWD) ? 1 : -1;
                    moved = 1;
                end
                DIR_LEFT, DIR_RIGHT:
                begin
                    c[0] = f[1] * up_v[2] - f[2] * up_v[1];
                    c[1] = f[2] * up_v[0] - f[0] * up_v[2];
                    c[2] = f[0] * up_v[1] - f[1] * up_v[0];
                    n = int_sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2]);
                    if (n == 0)
                        degen = 1;
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                            v[i] = unit_part(c[i], n);
                        sgn = (op.dir == DIR_RIGHT) ? 1 : -1;
                        moved = 1;
                    end
                end
                DIR_UP, DIR_DOWN:
                begin
                    v = up_v;
                    sgn = (op.dir == DIR_UP) ? 1 : -1;
                    moved = 1;
                end
                default: ;
            endcase
            if (moved)
                for (int i = 0; i < 3; i++)
                    pos_v[i] = clip(pos_v[i] + sgn * round_shr(vel * v[i], 14),
                                    -64'sd2147483648, 64'sd2147483647);
        end
        r.px = pos_v[0][31:0];
        r.py = pos_v[1][31:0];
        r.pz = pos_v[2][31:0];
        r.fx = f[0][15:0];
        r.fy = f[1][15:0];
        r.fz = f[2][15:0];
        r.yaw = yaw_q[24:0];
        r.pitch = pitch_q[23:0];
        r.degen = degen;
        return r;
    endfunction

    // Stream driver: events go out with random gaps, register writes wait for an idle core
    always @(posedge clk or negedge rst_n)
    begin
        op_t  op;
        bit   v_n, we_n, load;
        int   g;
        if (!rst_n)
        begin
            s_valid <= 1'b0;
            cfg_we <= 1'b0;
        end
        else
        begin
            v_n = s_valid;
            we_n = 1'b0;
            load = 0;
            if (s_valid && s_ready)
            begin
                pose_due.push_back(next_pose(cur_op));
                n_events++;
                v_n = 1'b0;
                g = cur_op.nogap ? 0 : $urandom_range(0, MAX_GAP);
                if (g == 0 && pending.size() > 0 && pending[0].kind == OP_EVENT)
                    load = 1;
                else
                    gap_left <= g;
            end
            else if (!s_valid)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (pending.size() > 0)
                begin
                    if (pending[0].kind == OP_EVENT)
                        load = 1;
                    else if (pose_due.size() == 0)
                    begin
                        // let the core finish any work before touching state
                        if (settle_cnt < SETTLE)
                            settle_cnt <= settle_cnt + 1;
                        else
                        begin
                            settle_cnt <= 0;
                            op = pending.pop_front();
                            if (op.kind == OP_CFG)
                            begin
                                we_n = 1'b1;
                                cfg_index <= op.idx;
                                cfg_data <= op.val;
                                apply_cfg(op.idx, op.val);
                                n_cfg++;
                            end
                        end
                    end
                end
            end
            if (load)
            begin
                op = pending.pop_front();
                cur_op = op;
                s_data <= {5'd0, op.yo, op.xo, op.dt, op.dir};
                s_user <= op.cmd;
                v_n = 1'b1;
            end
            s_valid <= v_n;
            cfg_we <= we_n;
        end
    end

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            n_fail++;
        end
    endtask

    // Result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        pose_t e;
        if (!rst_n)
            m_ready <= 1'b0;
        else if (m_valid && m_ready)
        begin
            n_results++;
            if (pose_due.size() == 0)
            begin
                $error("result with no pending expectation");
                n_fail++;
            end
            else
            begin
                e = pose_due.pop_front();
                if (e.degen)
                    n_degen++;
                check_field("pos_x", e.px, m_data[31:0]);
                check_field("pos_y", e.py, m_data[63:32]);
                check_field("pos_z", e.pz, m_data[95:64]);
                check_field("front_x", e.fx, m_data[111:96]);
                check_field("front_y", e.fy, m_data[127:112]);
                check_field("front_z", e.fz, m_data[143:128]);
                check_field("yaw_out", e.yaw, m_data[168:144]);
                check_field("pitch_out", e.pitch, m_data[192:169]);
                check_field("degenerate", e.degen, m_user[0]);
            end
            // every third run of 60 results goes without stalls
            stall_left <= ((n_results / 60) % 3 == 0) ? 0 : $urandom_range(0, MAX_GAP);
            if ((n_results / 60) % 3 != 0)
                m_ready <= 1'b0;
        end
        else if (!m_ready)
        begin
            if (stall_left > 0)
                stall_left <= stall_left - 1;
            else
                m_ready <= 1'b1;
        end
    end

    task automatic add_event(logic cmd, logic [2:0] dir, logic [15:0] dt,
                             logic [15:0] xo, logic [15:0] yo, bit nogap);
        op_t op;
        op.kind = OP_EVENT;
        op.cmd = cmd;
        op.dir = dir;
        op.dt = dt;
        op.xo = xo;
        op.yo = yo;
        op.idx = '0;
        op.val = '0;
        op.nogap = nogap;
        pending.push_back(op);
    endtask

    task automatic add_cfg(logic [2:0] idx, logic [31:0] val);
        op_t op;
        op = '{kind: OP_CFG, cmd: 1'b0, dir: 3'd0, dt: 16'd0, xo: 16'd0, yo: 16'd0,
               idx: idx, val: val, nogap: 0};
        pending.push_back(op);
    endtask

    function automatic logic [31:0] rand_up();
        int k;
        k = $urandom_range(0, 5);
        if (k == 0)
            return 32'(16384);
        if (k == 1)
            return -32'sd16384;
        return 32'(longint'($urandom_range(0, 32768)) - 16384);
    endfunction

    // Pick a fresh setting of all registers, extremes now and then
    task automatic add_setting();
        int k;
        k = $urandom_range(0, 3);
        add_cfg(REG_UP_X, rand_up());
        add_cfg(REG_UP_Y, rand_up());
        add_cfg(REG_UP_Z, rand_up());
        add_cfg(REG_START_X, k == 0 ? 32'h7fff0000 : $urandom);
        add_cfg(REG_START_Y, k == 1 ? 32'h80010000 : $urandom);
        add_cfg(REG_START_Z, $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 65535)));
        add_cfg(REG_START_YAW, $urandom);
        add_cfg(REG_START_PITCH, $urandom);
    endtask

    initial
    begin
        bit   calm;
        int   pick;
        logic [15:0] xo, yo;
        up_v = '{0, 16384, 0};
        pos_v = '{0, 0, 0};
        yaw_q = -DEG90;
        pitch_q = 0;

        // directed: reset pose, every direction, extremes and the odd cases
        add_event(CMD_MOVE, DIR_FWD, 16'hffff, 16'h0000, 16'h0000, 0);
        add_event(CMD_MOVE, DIR_BACK, 16'h0000, 16'hffff, 16'hffff, 0);
        add_event(CMD_MOVE, DIR_LEFT, 16'h8000, 16'h0000, 16'h0000, 1);
        add_event(CMD_MOVE, DIR_RIGHT, 16'hffff, 16'h0000, 16'h0000, 1);
        add_event(CMD_MOVE, DIR_UP, 16'hffff, 16'h0000, 16'h0000, 0);
        add_event(CMD_MOVE, DIR_DOWN, 16'h0001, 16'h0000, 16'h0000, 0);
        add_event(CMD_MOVE, 3'd6, 16'hffff, 16'h7fff, 16'h8000, 0);
        add_event(CMD_MOVE, 3'd7, 16'hffff, 16'h8000, 16'h7fff, 0);
        add_event(CMD_LOOK, DIR_FWD, 16'hffff, 16'h7fff, 16'h7fff, 0);
        add_event(CMD_LOOK, 3'd7, 16'h0000, 16'h8000, 16'h8000, 1);
        add_event(CMD_LOOK, DIR_FWD, 16'h0000, 16'h7fff, 16'h0000, 1);
        add_event(CMD_MOVE, DIR_LEFT, 16'hffff, 16'h0000, 16'h0000, 0);
        // zero up vector: sideways moves have no cross product
        add_cfg(REG_UP_X, 32'd0);
        add_cfg(REG_UP_Y, 32'd0);
        add_cfg(REG_UP_Z, 32'd0);
        add_event(CMD_MOVE, DIR_LEFT, 16'hffff, 16'h0000, 16'h0000, 0);
        add_event(CMD_MOVE, DIR_RIGHT, 16'hffff, 16'h0000, 16'h0000, 0);
        // positions at the rails, yaw and pitch written out of range
        add_cfg(REG_UP_X, 32'(16384));
        add_cfg(REG_UP_Y, -32'sd16384);
        add_cfg(REG_UP_Z, 32'(16384));
        add_cfg(REG_START_X, 32'h7fffffff);
        add_cfg(REG_START_Y, 32'h80000000);
        add_cfg(REG_START_Z, 32'h7ffffff0);
        add_cfg(REG_START_YAW, 32'h00ffffff);
        add_cfg(REG_START_PITCH, 32'h007fffff);
        add_event(CMD_MOVE, DIR_UP, 16'hffff, 16'h0000, 16'h0000, 0);
        add_event(CMD_MOVE, DIR_DOWN, 16'hffff, 16'h0000, 16'h0000, 0);
        add_event(CMD_MOVE, DIR_RIGHT, 16'hffff, 16'h0000, 16'h0000, 0);
        add_cfg(REG_START_YAW, 32'h01000000);
        add_cfg(REG_START_PITCH, 32'h00800000);
        add_event(CMD_MOVE, DIR_FWD, 16'hffff, 16'h0000, 16'h0000, 0);
        add_event(CMD_LOOK, DIR_FWD, 16'h0000, 16'h0010, 16'hfff0, 0);

        // random phases: new register setting, then a run of events
        calm = 0;
        for (int i = 0; i < 1880; i++)
        begin
            if (i % 150 == 0)
            begin
                add_setting();
                calm = $urandom_range(0, 2) == 0;
            end
            if (i == 900)
                pending.push_back('{kind: OP_DRAIN, cmd: 1'b0, dir: 3'd0, dt: 16'd0,
                                    xo: 16'd0, yo: 16'd0, idx: 3'd0, val: 32'd0,
                                    nogap: 0});
            pick = $urandom_range(0, 15);
            xo = (pick < 12) ? 16'(longint'($urandom_range(0, 2047)) - 1024) : 16'($urandom);
            yo = (pick < 13) ? 16'(longint'($urandom_range(0, 511)) - 256) : 16'($urandom);
            add_event($urandom_range(0, 2) == 0 ? CMD_LOOK : CMD_MOVE,
                      ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                  : 3'($urandom_range(0, 5)),
                      16'($urandom), xo, yo, calm);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() > 0 || s_valid || pose_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d events (%0d degenerate side moves) and %0d register writes,",
                 n_events, n_degen, n_cfg);
        $display("with random stalls on both streams; %0d results checked.", n_results);
        if (n_fail == 0 && pose_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
hw/rtl/fcpu_pkg.sv
hw/rtl/fly_camera_pose_update_core.sv
dv/tb.sv
